>>> src/keypad_decimal_calculator_7seg_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keypad calculator
// Shared implication checks, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DECIMAL_CALCULATOR_7SEG_TOP_ASSERT_SVH
`define KEYPAD_DECIMAL_CALCULATOR_7SEG_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define KDC7_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define KDC7_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kdc7_pkg.sv
// ----------------------------------------------------------------------------
// kdc7_pkg
// Types, constants and small decode functions for the keypad calculator.
// ----------------------------------------------------------------------------
package kdc7_pkg;

    localparam int unsigned VAL_W = 14;

    localparam logic [VAL_W-1:0] NUM_MAX = 14'd9999;

    // Segment patterns for the error text
    localparam logic [6:0] PAT_E     = 7'h7C;
    localparam logic [6:0] PAT_R     = 7'h48;
    localparam logic [6:0] PAT_BLANK = 7'h00;

    // What the display is asked to show
    typedef enum logic [1:0] {
        DISP_BLANK,
        DISP_NUM,
        DISP_ERR
    } disp_mode_t;

    // One decimal digit split off a value, with what remains
    typedef struct packed {
        logic [3:0]       digit;
        logic [VAL_W-1:0] rem;
    } dec_split_t;

    // Digit for one decimal place: nine parallel compares, top hit wins
    function automatic dec_split_t dec_split(input logic [VAL_W-1:0] value,
                                             input logic [VAL_W-1:0] unit);
        dec_split_t       res;
        logic [VAL_W-1:0] step;
        res.digit = 4'd0;
        res.rem   = value;
        for (int k = 1; k <= 9; k++) begin
            step = unit * VAL_W'(k);
            if (value >= step) begin
                res.digit = 4'(k);
                res.rem   = value - step;
            end
        end
        return res;
    endfunction

    // Seven-segment pattern for a decimal digit
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        unique case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h03;
            4'd2:    p = 7'h6D;
            4'd3:    p = 7'h67;
            4'd4:    p = 7'h53;
            4'd5:    p = 7'h76;
            4'd6:    p = 7'h7E;
            4'd7:    p = 7'h23;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h77;
            default: p = PAT_BLANK;
        endcase
        return p;
    endfunction

    // Append a keypad digit: v*10 + key, held at the four-digit limit
    function automatic logic [VAL_W-1:0] append_digit(input logic [VAL_W-1:0] v,
                                                      input logic [3:0]       key);
        logic [VAL_W+3:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {(VAL_W)'(0), key};
        return (n > {4'd0, NUM_MAX}) ? NUM_MAX : n[VAL_W-1:0];
    endfunction

endpackage

>>> src/keypad_decimal_calculator_7seg_top.sv
// ----------------------------------------------------------------------------
// keypad_decimal_calculator_7seg_top
// Two-operand decimal calculator driving four seven-segment digits.
// ----------------------------------------------------------------------------
// Each item is one sample of the four toggles and a keypad nibble. Toggle 3
// appends the key to operand A, toggle 2 to operand B (A first when both are
// on); toggle 1 shows A+B and toggle 0 shows A-B, the lowest-numbered active
// toggle deciding the display. Operands saturate at 9999; an oversized sum or a
// negative difference shows " Err" with error_shown set, and no toggle gives
// a blank display. One item is taken every cycle while the result side keeps
// up: the operand update and display selection finish in the accept cycle, and
// the decimal digits are split over the following stages, registered in turn in
// stage 2, stage 3 and the output register. The whole pipeline holds while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module keypad_decimal_calculator_7seg_top (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_toggles,
    input  logic [3:0] s_key_value,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_seg_thousands,
    output logic [6:0] m_seg_hundreds,
    output logic [6:0] m_seg_tens,
    output logic [6:0] m_seg_ones,
    output logic       m_error_shown
);

    localparam int unsigned VW = kdc7_pkg::VAL_W;

    // Pipeline moves as one while the output register is free or being emptied
    logic advance;
    logic in_fire;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign in_fire = s_valid && s_ready;

    // ---------------------------------------------------------------- stage 1
    logic [VW-1:0]          operand_a_reg, operand_a_next;
    logic [VW-1:0]          operand_b_reg, operand_b_next;
    logic [VW:0]            sum_full;
    logic                   p1_valid_reg;
    kdc7_pkg::disp_mode_t   p1_mode_reg, p1_mode_next;
    logic [VW-1:0]          p1_value_reg, p1_value_next;

    // Operand update: A before B, both with the same key
    always_comb begin
        operand_a_next = s_toggles[3] ?
                         kdc7_pkg::append_digit(operand_a_reg, s_key_value) : operand_a_reg;
        operand_b_next = s_toggles[2] ?
                         kdc7_pkg::append_digit(operand_b_reg, s_key_value) : operand_b_reg;
        sum_full       = {1'b0, operand_a_next} + {1'b0, operand_b_next};
    end

    // Display choice: the last active toggle in order 3..0 wins
    always_comb begin
        p1_mode_next  = kdc7_pkg::DISP_BLANK;
        p1_value_next = '0;
        priority if (s_toggles[0]) begin
            if (operand_a_next < operand_b_next) begin
                p1_mode_next = kdc7_pkg::DISP_ERR;
            end else begin
                p1_mode_next  = kdc7_pkg::DISP_NUM;
                p1_value_next = operand_a_next - operand_b_next;
            end
        end else if (s_toggles[1]) begin
            if (sum_full > {1'b0, kdc7_pkg::NUM_MAX}) begin
                p1_mode_next = kdc7_pkg::DISP_ERR;
            end else begin
                p1_mode_next  = kdc7_pkg::DISP_NUM;
                p1_value_next = sum_full[VW-1:0];
            end
        end else if (s_toggles[2]) begin
            p1_mode_next  = kdc7_pkg::DISP_NUM;
            p1_value_next = operand_b_next;
        end else if (s_toggles[3]) begin
            p1_mode_next  = kdc7_pkg::DISP_NUM;
            p1_value_next = operand_a_next;
        end else begin
            p1_mode_next = kdc7_pkg::DISP_BLANK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operand_a_reg <= '0;
            operand_b_reg <= '0;
        end else if (in_fire) begin
            operand_a_reg <= operand_a_next;
            operand_b_reg <= operand_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_mode_reg  <= p1_mode_next;
            p1_value_reg <= p1_value_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Thousands digit
    kdc7_pkg::dec_split_t   thou_split;
    logic                   p2_valid_reg;
    kdc7_pkg::disp_mode_t   p2_mode_reg;
    logic [3:0]             p2_thou_reg;
    logic [9:0]             p2_rem_reg;

    assign thou_split = kdc7_pkg::dec_split(p1_value_reg, VW'(1000));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p2_mode_reg <= p1_mode_reg;
            p2_thou_reg <= thou_split.digit;
            p2_rem_reg  <= thou_split.rem[9:0];
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Hundreds digit
    kdc7_pkg::dec_split_t   hund_split;
    logic                   p3_valid_reg;
    kdc7_pkg::disp_mode_t   p3_mode_reg;
    logic [3:0]             p3_thou_reg;
    logic [3:0]             p3_hund_reg;
    logic [6:0]             p3_rem_reg;

    assign hund_split = kdc7_pkg::dec_split(VW'(p2_rem_reg), VW'(100));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (advance) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p3_mode_reg <= p2_mode_reg;
            p3_thou_reg <= p2_thou_reg;
            p3_hund_reg <= hund_split.digit;
            p3_rem_reg  <= hund_split.rem[6:0];
        end
    end

    // ---------------------------------------------------------------- output
    // Tens and ones, leading-zero blanking and pattern decode
    kdc7_pkg::dec_split_t   tens_split;
    logic                   m_valid_reg;
    logic [6:0]             seg_th_reg, seg_th_next;
    logic [6:0]             seg_hu_reg, seg_hu_next;
    logic [6:0]             seg_te_reg, seg_te_next;
    logic [6:0]             seg_on_reg, seg_on_next;
    logic                   err_reg, err_next;
    logic                   th_lit, hu_lit, te_lit;

    assign tens_split = kdc7_pkg::dec_split(VW'(p3_rem_reg), VW'(10));
    assign th_lit     = (p3_thou_reg != 4'd0);
    assign hu_lit     = th_lit || (p3_hund_reg != 4'd0);
    assign te_lit     = hu_lit || (tens_split.digit != 4'd0);

    always_comb begin
        unique case (p3_mode_reg)
            kdc7_pkg::DISP_NUM: begin
                seg_th_next = th_lit ? kdc7_pkg::seg_pattern(p3_thou_reg)
                                     : kdc7_pkg::PAT_BLANK;
                seg_hu_next = hu_lit ? kdc7_pkg::seg_pattern(p3_hund_reg)
                                     : kdc7_pkg::PAT_BLANK;
                seg_te_next = te_lit ? kdc7_pkg::seg_pattern(tens_split.digit)
                                     : kdc7_pkg::PAT_BLANK;
                seg_on_next = kdc7_pkg::seg_pattern(tens_split.rem[3:0]);
                err_next    = 1'b0;
            end
            kdc7_pkg::DISP_ERR: begin
                seg_th_next = kdc7_pkg::PAT_BLANK;
                seg_hu_next = kdc7_pkg::PAT_E;
                seg_te_next = kdc7_pkg::PAT_R;
                seg_on_next = kdc7_pkg::PAT_R;
                err_next    = 1'b1;
            end
            default: begin
                seg_th_next = kdc7_pkg::PAT_BLANK;
                seg_hu_next = kdc7_pkg::PAT_BLANK;
                seg_te_next = kdc7_pkg::PAT_BLANK;
                seg_on_next = kdc7_pkg::PAT_BLANK;
                err_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            seg_th_reg <= seg_th_next;
            seg_hu_reg <= seg_hu_next;
            seg_te_reg <= seg_te_next;
            seg_on_reg <= seg_on_next;
            err_reg    <= err_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_seg_thousands = seg_th_reg;
    assign m_seg_hundreds  = seg_hu_reg;
    assign m_seg_tens      = seg_te_reg;
    assign m_seg_ones      = seg_on_reg;
    assign m_error_shown   = err_reg;

    // ------------------------------------------------------------- assertions
`include "keypad_decimal_calculator_7seg_top_assert.svh"

    `KDC7_ASSERT_SAME(a_operand_limit, 1'b1, (operand_a_reg <= kdc7_pkg::NUM_MAX) && (operand_b_reg <= kdc7_pkg::NUM_MAX), "operand above 9999")
    `KDC7_ASSERT_NEXT(a_operand_hold, !in_fire, $stable(operand_a_reg) && $stable(operand_b_reg), "operand changed without an item")
    `KDC7_ASSERT_SAME(a_err_text, m_valid && m_error_shown, (m_seg_thousands == kdc7_pkg::PAT_BLANK) && (m_seg_hundreds == kdc7_pkg::PAT_E) && (m_seg_ones == kdc7_pkg::PAT_R), "error display malformed")

endmodule

>>> tb/sv/kdc7_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdc7_tb_pkg
// Display predictor and result scoreboard for the keypad calculator bench.
// ----------------------------------------------------------------------------
package kdc7_tb_pkg;

    import kdc7_pkg::*;

    // Toggle bit positions, in the order they are handled
    localparam int TOG_APPEND_A = 3;
    localparam int TOG_APPEND_B = 2;
    localparam int TOG_SUM      = 1;
    localparam int TOG_DIFF     = 0;

    // Segment patterns for decimal digits 0..9
    localparam logic [6:0] DIGIT_SEG [10] = '{
        7'h3F, 7'h03, 7'h6D, 7'h67, 7'h53, 7'h76, 7'h7E, 7'h23, 7'h7F, 7'h77
    };

    // One result item: four digit patterns and the error flag
    typedef struct packed {
        logic [6:0] thousands;
        logic [6:0] hundreds;
        logic [6:0] tens;
        logic [6:0] ones;
        logic       error_shown;
    } display_t;

    class display_scoreboard;

        logic [VAL_W-1:0] acc_a;
        logic [VAL_W-1:0] acc_b;
        display_t         expected_q[$];
        int unsigned      mismatches;
        int unsigned      samples_noted;
        int unsigned      displays_checked;
        int unsigned      error_displays;

        function new();
            acc_a = '0;
            acc_b = '0;
            mismatches = 0;
            samples_noted = 0;
            displays_checked = 0;
            error_displays = 0;
        endfunction

        // Decimal rendering, leading zeros blanked, ones always lit
        function display_t number_display(int unsigned n);
            display_t d;
            d.thousands   = (n >= 1000) ? DIGIT_SEG[(n / 1000) % 10] : PAT_BLANK;
            d.hundreds    = (n >= 100)  ? DIGIT_SEG[(n / 100) % 10]  : PAT_BLANK;
            d.tens        = (n >= 10)   ? DIGIT_SEG[(n / 10) % 10]   : PAT_BLANK;
            d.ones        = DIGIT_SEG[n % 10];
            d.error_shown = 1'b0;
            return d;
        endfunction

        // " Err" text
        function display_t error_display();
            display_t d;
            d.thousands   = PAT_BLANK;
            d.hundreds    = PAT_E;
            d.tens        = PAT_R;
            d.ones        = PAT_R;
            d.error_shown = 1'b1;
            return d;
        endfunction

        // v*10 + key, held at the four-digit limit
        function logic [VAL_W-1:0] grown(logic [VAL_W-1:0] v, logic [3:0] key);
            int unsigned n;
            n = int'(v) * 10 + int'(key);
            if (n > int'(NUM_MAX))
                n = int'(NUM_MAX);
            return VAL_W'(n);
        endfunction

        // Accepted input item: update operands, queue the display it yields
        function void note_sample(logic [3:0] toggles, logic [3:0] key);
            display_t    d;
            int unsigned total;
            d = '0;
            if (toggles[TOG_APPEND_A]) begin
                acc_a = grown(acc_a, key);
                d = number_display(acc_a);
            end
            if (toggles[TOG_APPEND_B]) begin
                acc_b = grown(acc_b, key);
                d = number_display(acc_b);
            end
            if (toggles[TOG_SUM]) begin
                total = int'(acc_a) + int'(acc_b);
                d = (total > int'(NUM_MAX)) ? error_display() : number_display(total);
            end
            if (toggles[TOG_DIFF]) begin
                d = (acc_a < acc_b) ? error_display()
                                    : number_display(int'(acc_a) - int'(acc_b));
            end
            expected_q.push_back(d);
            samples_noted++;
        endfunction

        // Accepted result item against the oldest expectation
        function void check_display(display_t got);
            display_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: display %h arrived with none expected", got);
                return;
            end
            want = expected_q.pop_front();
            displays_checked++;
            if (want.error_shown)
                error_displays++;
            if (got.thousands != want.thousands || got.hundreds != want.hundreds ||
                got.tens != want.tens || got.ones != want.ones ||
                got.error_shown != want.error_shown) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at display %0d: expected %h %h %h %h err %b, got %h %h %h %h err %b",
                             displays_checked, want.thousands, want.hundreds, want.tens,
                             want.ones, want.error_shown, got.thousands, got.hundreds,
                             got.tens, got.ones, got.error_shown);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad seven-segment calculator.
// ----------------------------------------------------------------------------
// Switch and keypad items go in over a valid/ready channel with random gaps;
// each accepted item is run through a local predictor of both operands and
// the display, and every display item that comes back is compared field by
// field with the oldest prediction. The result side stalls at random too.
// ----------------------------------------------------------------------------
module testbench;

    import kdc7_pkg::*;
    import kdc7_tb_pkg::*;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [3:0] s_toggles   = 4'd0;
    logic [3:0] s_key_value = 4'd0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [6:0] m_seg_thousands;
    logic [6:0] m_seg_hundreds;
    logic [6:0] m_seg_tens;
    logic [6:0] m_seg_ones;
    logic       m_error_shown;

    // No random idling on either side while set
    bit steady = 1'b0;

    display_scoreboard sb;

    keypad_decimal_calculator_7seg_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_toggles       (s_toggles),
        .s_key_value     (s_key_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_seg_thousands (m_seg_thousands),
        .m_seg_hundreds  (m_seg_hundreds),
        .m_seg_tens      (m_seg_tens),
        .m_seg_ones      (m_seg_ones),
        .m_error_shown   (m_error_shown)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check taken items, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_display({m_seg_thousands, m_seg_hundreds, m_seg_tens,
                              m_seg_ones, m_error_shown});
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // Present one item, with a random gap first, and wait for it to be taken
    task automatic send_sample(input logic [3:0] tog, input logic [3:0] key);
        int unsigned gap;
        gap = 0;
        if (!steady)
            while (gap < 6 && $urandom_range(99) < 38)
                gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_toggles   <= tog;
        s_key_value <= key;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(tog, key);
    endtask

    // Mostly display requests, some appends, the odd arbitrary mix
    task automatic random_samples(input int unsigned count);
        int unsigned pick;
        logic [3:0]  tog;
        for (int unsigned i = 0; i < count; i++) begin
            steady = (i >= 600 && i < 900);
            pick = $urandom_range(99);
            if (pick < 12)
                tog = 4'($urandom_range(4, 15));
            else if (pick < 90)
                tog = 4'($urandom_range(0, 3));
            else
                tog = 4'($urandom_range(0, 15));
            send_sample(tog, 4'($urandom_range(0, 15)));
        end
        steady = 1'b0;
    endtask

    localparam logic [3:0] T_NONE = 4'b0000;
    localparam logic [3:0] T_A    = 4'(1 << TOG_APPEND_A);
    localparam logic [3:0] T_B    = 4'(1 << TOG_APPEND_B);
    localparam logic [3:0] T_SUM  = 4'(1 << TOG_SUM);
    localparam logic [3:0] T_DIFF = 4'(1 << TOG_DIFF);

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: small operands first, saturation last
        send_sample(T_NONE, 4'd15);                    // blank display
        send_sample(T_SUM, 4'd0);                      // zero sum
        send_sample(T_DIFF, 4'd0);                     // zero difference
        send_sample(T_B, 4'd15);                       // key above nine
        send_sample(T_DIFF, 4'd3);                     // negative difference
        send_sample(T_SUM | T_DIFF, 4'd0);             // difference wins
        send_sample(T_A | T_B, 4'd7);                  // both appends, A first
        send_sample(T_A | T_B | T_SUM | T_DIFF, 4'd0); // every switch
        send_sample(T_A, 4'd9);                        // zero inside a number
        send_sample(T_A, 4'd9);                        // four digits
        send_sample(T_SUM, 4'd1);
        send_sample(T_DIFF, 4'd2);
        send_sample(T_A | T_SUM, 4'd0);                // A saturates, sum too large
        send_sample(T_A, 4'd15);                       // stays at the limit
        send_sample(T_DIFF, 4'd8);
        send_sample(T_A | T_DIFF, 4'd3);
        send_sample(T_B, 4'd8);                        // B saturates
        send_sample(T_SUM, 4'd4);
        send_sample(T_DIFF, 4'd5);
        send_sample(T_NONE, 4'd0);

        random_samples(1930);
        s_valid <= 1'b0;

        // Drain, then give stray items a chance to show up
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d switch samples and %0d displays checked, %0d of them Err.",
                 sb.samples_noted, sb.displays_checked, sb.error_displays);
        $display("Mismatches: %0d, predictions left over: %0d.", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/kdc7_pkg.sv
src/keypad_decimal_calculator_7seg_top.sv
tb/sv/kdc7_tb_pkg.sv
tb/sv/testbench.sv
